// ----- hdl/shed_pkg.sv -----
// shared types and constants for the sustained high episode detector
// no dependencies; imported by every module of the block but the checker
package shed_pkg;

  // default sizes for the top level parameters
  localparam int unsigned IndexBitsDef = 16;
  localparam int unsigned CountBitsDef = 10;

  // fixed field widths
  localparam int unsigned CfgW     = 10;
  localparam int unsigned GlucoseW = 10;
  localparam int unsigned OutIdxW  = 16;
  localparam int unsigned CfgIdxW  = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegHighThreshold   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMinCoreReadings = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMinRecReadings  = 2'd2;

  // configuration reset values
  localparam logic [CfgW-1:0] HighThresholdRst   = 10'd250;
  localparam logic [CfgW-1:0] MinCoreReadingsRst = 10'd24;
  localparam logic [CfgW-1:0] MinRecReadingsRst  = 10'd3;

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhCore    = 2'd1,
    PhRecover = 2'd2
  } shed_phase_e;

  // one sample as it sits in the input stage
  typedef struct packed {
    logic [GlucoseW-1:0] glucose;
    logic                sample_valid;
    logic                segment_last;
  } shed_sample_t;

  // one episode report
  typedef struct packed {
    logic                recovered;
    logic [OutIdxW-1:0]  confirm_index;
    logic [OutIdxW-1:0]  last_high_idx;
    logic [OutIdxW-1:0]  onset_idx;
  } shed_result_t;

  // thresholds handed from the register file to the core
  typedef struct packed {
    logic [CfgW-1:0] high_threshold;
    logic [CfgW-1:0] min_core_readings;
    logic [CfgW-1:0] min_rec_readings;
  } shed_cfg_t;

endpackage

// ----- hdl/shed_in_reg.sv -----
// input stage register of the episode detector
// depends on shed_pkg
module shed_in_reg import shed_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  shed_sample_t in_sample_i,
  output logic         st_valid_o,
  input  logic         st_take_i,
  output shed_sample_t st_sample_o
);

  logic         valid_q, valid_d;
  shed_sample_t sample_q;

  // stage frees up when its beat is taken by the core
  assign in_ready_o = !valid_q || st_take_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !st_take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q <= in_sample_i;
    end
  end

  assign st_valid_o  = valid_q;
  assign st_sample_o = sample_q;

endmodule

// ----- hdl/shed_core.sv -----
// episode tracking state and per-sample update logic
// depends on shed_pkg
module shed_core import shed_pkg::*; #(
  parameter int unsigned INDEX_BITS = IndexBitsDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         fire_i,
  input  shed_sample_t sample_i,
  input  shed_cfg_t    cfg_i,
  output logic         res_valid_o,
  output shed_result_t res_o
);

  localparam int unsigned CmpW = (COUNT_BITS > CfgW) ? COUNT_BITS : CfgW;

  shed_phase_e            phase_q, phase_d;
  logic [INDEX_BITS-1:0]  idx_q, idx_d;
  logic [INDEX_BITS-1:0]  run_start_q, run_start_d;
  logic [INDEX_BITS-1:0]  core_last_q, core_last_d;
  logic [INDEX_BITS-1:0]  latest_q, latest_d;
  logic [COUNT_BITS-1:0]  run_cnt_q, run_cnt_d;
  logic [COUNT_BITS-1:0]  rec_cnt_q, rec_cnt_d;
  logic [COUNT_BITS-1:0]  run_inc, rec_inc;
  logic [INDEX_BITS-1:0]  idx_inc;
  logic                   high;

  assign high    = sample_i.glucose > cfg_i.high_threshold;
  assign run_inc = (run_cnt_q == '1) ? run_cnt_q : run_cnt_q + 1'b1;
  assign rec_inc = (rec_cnt_q == '1) ? rec_cnt_q : rec_cnt_q + 1'b1;
  assign idx_inc = (idx_q == '1) ? idx_q : idx_q + 1'b1;

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    run_start_d = run_start_q;
    core_last_d = core_last_q;
    latest_d    = latest_q;
    run_cnt_d   = run_cnt_q;
    rec_cnt_d   = rec_cnt_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (sample_i.sample_valid) begin
      if (phase_q == PhIdle) begin
        if (high) begin
          if (run_cnt_q == '0) begin
            run_start_d = idx_q;
          end
          run_cnt_d   = run_inc;
          core_last_d = idx_q;
          latest_d    = idx_q;
          if (CmpW'(run_inc) >= CmpW'(cfg_i.min_core_readings)) begin
            phase_d   = PhCore;
            rec_cnt_d = '0;
          end
        end else begin
          run_cnt_d = '0;
        end
      end else begin
        if (high) begin
          latest_d = idx_q;
          if (phase_q == PhCore) begin
            core_last_d = idx_q;
          end
          rec_cnt_d = '0;
        end else begin
          phase_d   = PhRecover;
          rec_cnt_d = rec_inc;
          if (CmpW'(rec_inc) >= CmpW'(cfg_i.min_rec_readings)) begin
            res_valid_o         = 1'b1;
            res_o.onset_idx     = OutIdxW'(run_start_q);
            res_o.last_high_idx = OutIdxW'(latest_q);
            res_o.confirm_index = OutIdxW'(idx_q);
            res_o.recovered     = 1'b1;
            phase_d             = PhIdle;
            run_cnt_d           = '0;
            rec_cnt_d           = '0;
          end
        end
      end
    end

    if (sample_i.segment_last) begin
      // open episode at segment end is reported unconfirmed
      if (!res_valid_o && phase_d != PhIdle) begin
        res_valid_o         = 1'b1;
        res_o.onset_idx     = OutIdxW'(run_start_d);
        res_o.last_high_idx = OutIdxW'(core_last_d);
        res_o.confirm_index = OutIdxW'(idx_q);
        res_o.recovered     = 1'b0;
      end
      phase_d     = PhIdle;
      idx_d       = '0;
      run_start_d = '0;
      core_last_d = '0;
      latest_d    = '0;
      run_cnt_d   = '0;
      rec_cnt_d   = '0;
    end else begin
      idx_d = idx_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      idx_q       <= '0;
      run_start_q <= '0;
      core_last_q <= '0;
      latest_q    <= '0;
      run_cnt_q   <= '0;
      rec_cnt_q   <= '0;
    end else if (fire_i) begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      run_start_q <= run_start_d;
      core_last_q <= core_last_d;
      latest_q    <= latest_d;
      run_cnt_q   <= run_cnt_d;
      rec_cnt_q   <= rec_cnt_d;
    end
  end

endmodule

// ----- hdl/shed_out_reg.sv -----
// result register of the episode detector
// depends on shed_pkg
module shed_out_reg import shed_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  shed_result_t res_i,
  output logic         free_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output shed_result_t res_o
);

  logic         valid_q, valid_d;
  shed_result_t res_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- hdl/sustained_high_episode_detector_unit.sv -----
// top level of the sustained high episode detector
// depends on shed_pkg, shed_in_reg, shed_core, shed_out_reg
//
// usage:
//   slave stream carries one glucose sample per beat; tuser flags the sample
//   as present, tlast marks the final sample of a segment
//   master stream carries one episode report per beat: start, reported end
//   and confirm index in tdata, the recovered flag in tuser
//   a sample causes at most one report; most samples cause none
//   the cfg port writes threshold and count registers at any clock with
//   cfg_we_i high; write only while no samples are in flight
// timing:
//   a sample goes through the input register and the update logic into the
//   result register; its report is registered there before it can leave;
//   one sample per cycle is sustained while the result register is free,
//   and the state update is the only loop
// reset:
//   clears the sample index, the episode state and both stage valid bits;
//   registers return to threshold 250, core count 24, recovery count 3
// stall:
//   a held report keeps its beat stable; the input register keeps filling
//   until it is full, then s_axis_tready drops
module sustained_high_episode_detector_unit import shed_pkg::*; #(
  parameter int unsigned INDEX_BITS = IndexBitsDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // sample stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,   // [9:0] glucose, rest zero
  input  logic               s_axis_tuser,   // [0] sample_valid
  input  logic               s_axis_tlast,   // segment_last
  // episode report stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [47:0]        m_axis_tdata,   // [15:0] start, [31:16] end, [47:32] confirm
  output logic               m_axis_tuser,   // [0] recovered
  // register write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  shed_cfg_t    cfg_q;
  shed_sample_t in_sample, st_sample;
  shed_result_t core_res, out_res;
  logic         st_valid, st_take, out_free, core_res_valid;

  // register file, writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_threshold    <= HighThresholdRst;
      cfg_q.min_core_readings <= MinCoreReadingsRst;
      cfg_q.min_rec_readings  <= MinRecReadingsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegHighThreshold:   cfg_q.high_threshold    <= cfg_data_i;
        RegMinCoreReadings: cfg_q.min_core_readings <= cfg_data_i;
        RegMinRecReadings:  cfg_q.min_rec_readings  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_sample.glucose      = s_axis_tdata[GlucoseW-1:0];
  assign in_sample.sample_valid = s_axis_tuser;
  assign in_sample.segment_last = s_axis_tlast;

  shed_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (in_sample),
    .st_valid_o  (st_valid),
    .st_take_i   (st_take),
    .st_sample_o (st_sample)
  );

  // the core only advances when the result register can take a report
  assign st_take = st_valid && out_free;

  shed_core #(
    .INDEX_BITS (INDEX_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (st_take),
    .sample_i    (st_sample),
    .cfg_i       (cfg_q),
    .res_valid_o (core_res_valid),
    .res_o       (core_res)
  );

  shed_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (st_take && core_res_valid),
    .res_i       (core_res),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (out_res)
  );

  assign m_axis_tdata = {out_res.confirm_index, out_res.last_high_idx, out_res.onset_idx};
  assign m_axis_tuser = out_res.recovered;

endmodule

// ----- hdl/shed_checker.sv -----
// port-level checks for the episode detector, bound to the top level
// depends on sustained_high_episode_detector_unit
module shed_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled report holds its beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("report changed while stalled");

  // episode indices are ordered start, end, confirm
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:0] <= m_axis_tdata[31:16]) &&
                      (m_axis_tdata[31:16] <= m_axis_tdata[47:32]))
    else $error("episode indices out of order");

  // no report right after reset release
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !m_axis_tvalid)
    else $error("report present right after reset");

endmodule

bind sustained_high_episode_detector_unit shed_checker u_shed_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
